[src/lis_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the longest increasing subsequence block.
package lis_pkg;

  // Width of the value fields on both channels.
  localparam int FIELD_WIDTH = 16;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] element_value;
    logic                          is_last;
  } lis_in_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] result_value;
    logic                          last_of_run;
    logic                          overflow;
  } lis_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_FINAL,
    ST_LINK,
    ST_DONE,
    ST_BT_TAIL,
    ST_BT_WALK,
    ST_EMIT_CHAIN,
    ST_EMIT_ELEM,
    ST_EMIT_LOAD
  } state_t;

endpackage

[src/lis_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream channel that carries one payload beat per handshake.
interface lis_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/longest_increasing_subsequence.sv]
`timescale 1ns / 1ps
// Longest strictly increasing subsequence engine with a binary-searched tails table.
//
// The block takes a list of signed values, one beat per value, with is_last set on
// the final beat, and answers with the longest strictly increasing subsequence of
// that list, in original order, one beat per value; last_of_run marks its final
// beat and overflow is set on every beat if the list held more than MAX_ITEMS
// values (the extra ones are dropped, though a dropped last beat still closes the
// list). Only the low min(VALUE_WIDTH, 16) bits of element_value count; results are
// sign-extended back to 16 bits. All tables sit in single-port-read memories, and
// the tails table is read once per cycle, which sets the pace: the first value of
// a list opens a run at once, a value above the last tail extends the longest run,
// any other stored value is placed by a binary search and replaces the tail found
// when strictly smaller, with its link written unless that tail is the first, and a
// dropped value only sets overflow. After the last beat the predecessor links are
// walked back, one per cycle, then the result streams, each beat read from the
// chain and value tables, through an output register, so a stalled consumer holds
// only the final beat while the block already takes the next list. No input is
// taken while a list is searched or its result is produced. Nothing needs clearing after reset.
module longest_increasing_subsequence #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  lis_stream_if.sink  items,
  lis_stream_if.source results
);
  import lis_pkg::*;

  localparam int EFF_WIDTH = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  localparam int IW        = $clog2(MAX_ITEMS);
  localparam int CW        = $clog2(MAX_ITEMS + 1);

  // Memories: stored values, tail table (index and a copy of the value), links,
  // and the reconstructed chain of indices in original order.
  logic signed [EFF_WIDTH-1:0] elem_mem  [MAX_ITEMS];
  logic        [IW-1:0]        tidx_mem  [MAX_ITEMS];
  logic signed [EFF_WIDTH-1:0] tval_mem  [MAX_ITEMS];
  logic        [IW-1:0]        pred_mem  [MAX_ITEMS];
  logic        [IW-1:0]        chain_mem [MAX_ITEMS];

  logic signed [EFF_WIDTH-1:0] elem_q;
  logic        [IW-1:0]        tidx_q;
  logic signed [EFF_WIDTH-1:0] tval_q;
  logic        [IW-1:0]        pred_q;
  logic        [IW-1:0]        chain_q;

  // Control registers.
  state_t          state, state_next;
  logic [CW-1:0]   tail_length, tail_length_next;
  logic [CW-1:0]   element_count, element_count_next;
  logic            dropped_flag, dropped_flag_next;
  logic            out_valid, out_valid_next;

  // Working registers.
  logic        [IW-1:0]        cur_idx, cur_idx_next;
  logic signed [EFF_WIDTH-1:0] cur_val, cur_val_next;
  logic                        cur_last, cur_last_next;
  logic        [IW-1:0]        lo, lo_next;
  logic        [IW-1:0]        hi, hi_next;
  logic        [IW-1:0]        probe, probe_next;
  logic        [CW-1:0]        walk_cnt, walk_cnt_next;
  logic        [IW-1:0]        emit_idx, emit_idx_next;
  lis_out_t                    out_data, out_data_next;

  // Memory port controls.
  logic                        elem_we;
  logic        [IW-1:0]        elem_raddr;
  logic                        tail_we;
  logic        [IW-1:0]        tail_waddr;
  logic        [IW-1:0]        tail_raddr;
  logic                        pred_we;
  logic        [IW-1:0]        pred_wdata;
  logic        [IW-1:0]        pred_raddr;
  logic                        chain_we;
  logic        [IW-1:0]        chain_waddr;
  logic        [IW-1:0]        chain_wdata;
  logic        [IW-1:0]        chain_raddr;

  logic                        take_item;
  logic                        has_room;
  logic signed [EFF_WIDTH-1:0] in_val;
  logic        [IW:0]          mid_sum;
  logic        [IW-1:0]        node;

  assign items.ready   = (state == ST_IDLE);
  assign take_item     = items.valid && items.ready;
  assign has_room      = (element_count != CW'(MAX_ITEMS));
  assign in_val        = items.data.element_value[EFF_WIDTH-1:0];
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Midpoint of the next search window, formed from the updated bounds.
  assign mid_sum = {1'b0, lo_next} + {1'b0, hi_next};

  // The link walk starts from the last tail and then follows predecessor reads.
  assign node = (state == ST_BT_TAIL) ? tidx_q : pred_q;

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[cur_idx_next] <= in_val;
    end
    elem_q <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tidx_mem[tail_waddr] <= cur_idx_next;
      tval_mem[tail_waddr] <= cur_val_next;
    end
    tidx_q <= tidx_mem[tail_raddr];
    tval_q <= tval_mem[tail_raddr];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[cur_idx] <= pred_wdata;
    end
    pred_q <= pred_mem[pred_raddr];
  end

  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_waddr] <= chain_wdata;
    end
    chain_q <= chain_mem[chain_raddr];
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tail_length   <= '0;
      element_count <= '0;
      dropped_flag  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      tail_length   <= tail_length_next;
      element_count <= element_count_next;
      dropped_flag  <= dropped_flag_next;
      out_valid     <= out_valid_next;
    end
  end

  // Working registers need no reset: each is loaded before it is used.
  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_val  <= cur_val_next;
    cur_last <= cur_last_next;
    lo       <= lo_next;
    hi       <= hi_next;
    probe    <= probe_next;
    walk_cnt <= walk_cnt_next;
    emit_idx <= emit_idx_next;
    out_data <= out_data_next;
  end

  // Sequencer: next state, register updates and memory strobes.
  always_comb begin
    state_next         = state;
    tail_length_next   = tail_length;
    element_count_next = element_count;
    dropped_flag_next  = dropped_flag;
    out_valid_next     = out_valid && !results.ready;
    cur_idx_next       = cur_idx;
    cur_val_next       = cur_val;
    cur_last_next      = cur_last;
    lo_next            = lo;
    hi_next            = hi;
    probe_next         = probe;
    walk_cnt_next      = walk_cnt;
    emit_idx_next      = emit_idx;
    out_data_next      = out_data;
    elem_we            = 1'b0;
    elem_raddr         = '0;
    tail_we            = 1'b0;
    tail_waddr         = '0;
    tail_raddr         = '0;
    pred_we            = 1'b0;
    pred_wdata         = tidx_q;
    pred_raddr         = '0;
    chain_we           = 1'b0;
    chain_waddr        = '0;
    chain_wdata        = node;
    chain_raddr        = '0;

    unique case (state)
      ST_IDLE: begin
        if (take_item) begin
          cur_idx_next  = element_count[IW-1:0];
          cur_val_next  = in_val;
          cur_last_next = items.data.is_last;
          if (has_room) begin
            elem_we            = 1'b1;
            element_count_next = element_count + 1'b1;
            if (tail_length == '0) begin
              // The first value of a list opens a run of length one.
              tail_we          = 1'b1;
              tail_waddr       = '0;
              tail_length_next = CW'(1);
              state_next       = ST_DONE;
            end else begin
              tail_raddr = IW'(tail_length - 1'b1);
              state_next = ST_CHECK;
            end
          end else begin
            dropped_flag_next = 1'b1;
            state_next        = ST_DONE;
          end
        end
      end

      ST_CHECK: begin
        if (tval_q < cur_val) begin
          // Above the last tail: extend the longest run.
          pred_we          = 1'b1;
          tail_we          = 1'b1;
          tail_waddr       = tail_length[IW-1:0];
          tail_length_next = tail_length + 1'b1;
          state_next       = ST_DONE;
        end else begin
          lo_next = '0;
          hi_next = IW'(tail_length - 1'b1);
          if (lo_next < hi_next) begin
            probe_next = mid_sum[IW:1];
            tail_raddr = probe_next;
            state_next = ST_PROBE;
          end else begin
            tail_raddr = lo_next;
            state_next = ST_FINAL;
          end
        end
      end

      ST_PROBE: begin
        if (tval_q < cur_val) begin
          lo_next = IW'({1'b0, probe} + 1'b1);
        end else begin
          hi_next = probe;
        end
        if (lo_next < hi_next) begin
          probe_next = mid_sum[IW:1];
          tail_raddr = probe_next;
        end else begin
          tail_raddr = lo_next;
          state_next = ST_FINAL;
        end
      end

      ST_FINAL: begin
        // Replace the first tail not below the value only when strictly smaller.
        if (cur_val < tval_q) begin
          tail_we    = 1'b1;
          tail_waddr = lo;
          if (lo != '0) begin
            tail_raddr = IW'(lo - 1'b1);
            state_next = ST_LINK;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_LINK: begin
        pred_we    = 1'b1;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (cur_last && (tail_length != '0)) begin
          tail_raddr    = IW'(tail_length - 1'b1);
          walk_cnt_next = tail_length;
          state_next    = ST_BT_TAIL;
        end else if (cur_last) begin
          tail_length_next   = '0;
          element_count_next = '0;
          dropped_flag_next  = 1'b0;
          state_next         = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_BT_TAIL, ST_BT_WALK: begin
        // Store the chain back to front while fetching the next link.
        chain_we      = 1'b1;
        chain_waddr   = IW'(walk_cnt - 1'b1);
        pred_raddr    = node;
        walk_cnt_next = walk_cnt - 1'b1;
        if (walk_cnt == CW'(1)) begin
          emit_idx_next = '0;
          state_next    = ST_EMIT_CHAIN;
        end else begin
          state_next = ST_BT_WALK;
        end
      end

      ST_EMIT_CHAIN: begin
        chain_raddr = emit_idx;
        state_next  = ST_EMIT_ELEM;
      end

      ST_EMIT_ELEM: begin
        chain_raddr = emit_idx;
        elem_raddr  = chain_q;
        state_next  = ST_EMIT_LOAD;
      end

      ST_EMIT_LOAD: begin
        // Keep both reads pointed at the current beat while the output is full.
        chain_raddr = emit_idx;
        elem_raddr  = chain_q;
        if (!out_valid || results.ready) begin
          out_valid_next             = 1'b1;
          out_data_next.result_value = FIELD_WIDTH'(elem_q);
          out_data_next.overflow     = dropped_flag;
          if ((CW'(emit_idx) + 1'b1) == tail_length) begin
            out_data_next.last_of_run = 1'b1;
            tail_length_next          = '0;
            element_count_next        = '0;
            dropped_flag_next         = 1'b0;
            state_next                = ST_IDLE;
          end else begin
            out_data_next.last_of_run = 1'b0;
            emit_idx_next             = emit_idx + 1'b1;
            state_next                = ST_EMIT_CHAIN;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
